### rtl/core/ecdd_pkg.sv
// Shared types and constants for the elevator call direction decider.
// No dependencies; imported by ecdd_decide and the top level.
`default_nettype none
package ecdd_pkg;

	// Building size and call mask geometry
	localparam int FLOORS = 9;
	localparam int CALL_W = 9;
	localparam logic [3:0] FLOOR_LIMIT = 4'(FLOORS);
	localparam logic [3:0] TOP_FLOOR = 4'(FLOORS - 1);
	localparam logic [CALL_W-1:0] ALL_MASK = CALL_W'((1 << FLOORS) - 1);
	localparam logic [CALL_W-1:0] NO_CALLS = '0;

	// Car motion codes; code three is unused and flagged as an error
	localparam logic [1:0] MOT_STOP = 2'd0;
	localparam logic [1:0] MOT_DOWN = 2'd1;
	localparam logic [1:0] MOT_UP = 2'd2;

	// Direction flag values
	localparam logic DIR_DOWN = 1'b0;
	localparam logic DIR_UP = 1'b1;

	typedef enum logic [1:0] {
		CMD_STAY = 2'd0,
		CMD_UP = 2'd1,
		CMD_DOWN = 2'd2,
		CMD_ERR = 2'd3
	} cmd_t;

	// Request: one car status update with newly pressed buttons
	typedef struct packed {
		logic [1:0] motion;
		logic [3:0] floor;
		logic [CALL_W-1:0] new_cabin_calls;
		logic [CALL_W-1:0] new_hall_calls;
	} call_req_t;

	// Response: one decision with the call state after it
	typedef struct packed {
		logic [1:0] command;
		logic heading;
		logic [CALL_W-1:0] pending_cabin;
		logic [CALL_W-1:0] pending_hall;
	} dec_rsp_t;

	// Decision unit result: command plus next state
	typedef struct packed {
		cmd_t command;
		logic heading;
		logic [CALL_W-1:0] cabin_next;
		logic [CALL_W-1:0] hall_next;
	} dec_t;

endpackage
`default_nettype wire

### rtl/core/ecdd_decide.sv
// Combinational direction decision for one request.
// Depends on ecdd_pkg for codes, geometry and the dec_t result struct.
`default_nettype none
module ecdd_decide (
	input wire logic [1:0] motion,
	input wire logic [3:0] floor,
	input wire logic [ecdd_pkg::CALL_W-1:0] cabin,
	input wire logic [ecdd_pkg::CALL_W-1:0] hall,
	input wire logic heading,
	output ecdd_pkg::dec_t dec
);
	import ecdd_pkg::*;

	logic [CALL_W-1:0] at_m;
	logic [CALL_W-1:0] lo_m;
	logic [CALL_W-1:0] hi_m;
	logic c_at, c_lo, c_hi, h_at, h_lo, h_hi;
	logic bad;
	logic end_floor;

	// Floor-relative masks: at, below and above, one compare each per floor bit
	always_comb begin
		for (int i = 0; i < CALL_W; i++) begin
			at_m[i] = (floor == 4'(i));
			lo_m[i] = (4'(i) < floor);
			hi_m[i] = (4'(i) > floor);
		end
	end

	assign c_at = |(cabin & at_m);
	assign c_lo = |(cabin & lo_m);
	assign c_hi = |(cabin & hi_m & ALL_MASK);
	assign h_at = |(hall & at_m);
	assign h_lo = |(hall & lo_m);
	assign h_hi = |(hall & hi_m & ALL_MASK);

	assign bad = (motion != MOT_STOP && motion != MOT_DOWN && motion != MOT_UP) ||
		(floor >= FLOOR_LIMIT);
	assign end_floor = (floor == 4'd0) || (floor == TOP_FLOOR);

	// Priority scan over calls at, below and above this floor; cabin calls generally outrank hall calls
	always_comb begin
		dec.command = CMD_STAY;
		dec.heading = heading;
		dec.cabin_next = cabin;
		dec.hall_next = hall;
		if (bad) begin
			dec.command = CMD_ERR;
		end else if (heading == DIR_DOWN) begin
			if (motion == MOT_UP) begin
				dec.command = CMD_ERR;
			end else if (motion == MOT_DOWN) begin
				if (c_at || h_at) dec.command = CMD_STAY;
				else if (c_lo || h_lo) dec.command = CMD_DOWN;
				else dec.command = CMD_STAY;
			end else begin
				if (c_at || h_at) begin
					dec.cabin_next = cabin & ~at_m;
					dec.hall_next = hall & ~at_m;
				end else if (c_lo) begin
					dec.command = CMD_DOWN;
				end else if (c_hi) begin
					dec.command = CMD_UP;
					dec.heading = DIR_UP;
				end else if (h_lo) begin
					dec.command = CMD_DOWN;
				end else if (h_hi) begin
					dec.command = CMD_UP;
					dec.heading = DIR_UP;
				end
			end
		end else begin
			if (motion == MOT_DOWN) begin
				dec.command = CMD_ERR;
			end else if (motion == MOT_UP) begin
				// nothing ahead while climbing: hold
				if (c_at) dec.command = CMD_STAY;
				else if (c_hi || h_hi) dec.command = CMD_UP;
				else dec.command = CMD_STAY;
			end else if (end_floor) begin
				if (c_at || h_at) begin
					dec.cabin_next = cabin & ~at_m;
					dec.hall_next = hall & ~at_m;
				end else if (c_lo) begin
					dec.command = CMD_DOWN;
					dec.heading = DIR_DOWN;
				end else if (c_hi) begin
					dec.command = CMD_UP;
				end else if (h_lo) begin
					dec.command = CMD_DOWN;
					dec.heading = DIR_DOWN;
				end else if (h_hi) begin
					dec.command = CMD_UP;
				end
			end else begin
				if (c_at) begin
					dec.cabin_next = cabin & ~at_m;
				end else if (c_hi) begin
					dec.command = CMD_UP;
				end else if (c_lo) begin
					// turn around; a hall call here is served first
					dec.heading = DIR_DOWN;
					if (h_at) dec.hall_next = hall & ~at_m;
					else dec.command = CMD_DOWN;
				end else if (h_at) begin
					dec.hall_next = hall & ~at_m;
				end else if (h_hi) begin
					dec.command = CMD_UP;
				end else if (h_lo) begin
					dec.command = CMD_DOWN;
					dec.heading = DIR_DOWN;
				end
			end
		end
	end

endmodule
`default_nettype wire

### rtl/core/elevator_call_direction_decider.sv
// Elevator call direction decider, top level.
// Depends on ecdd_pkg and ecdd_decide.
//
// Usage:
//   Request channel (call_valid / call_stall / call_req) carries the car's
//   motion, floor and newly pressed cabin and hall buttons. New buttons are
//   ORed into the stored call masks, then one command is chosen: stay, up,
//   down or error. Response channel (dec_valid / dec_stall / dec_rsp) returns
//   the command, the direction flag and both call masks after the request.
//   Path: a request is captured in the input register, then passes through
//   the decision logic into the response register.
//   Throughput: one request per cycle unless dec_stall holds; a decision is
//   a single pass of masked OR reductions over the call bits plus a priority
//   select; the call state updates as each request moves into the response register.
//   Stall: while dec_stall holds a waiting response, one more request is
//   held in the input register; call_stall rises only when that register is
//   full and cannot move on.
//   Reset: call masks clear, direction flag goes to down, both registers
//   empty.
`default_nettype none
module elevator_call_direction_decider (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic call_valid,
	output logic call_stall,
	input wire ecdd_pkg::call_req_t call_req,
	output logic dec_valid,
	input wire logic dec_stall,
	output ecdd_pkg::dec_rsp_t dec_rsp
);
	import ecdd_pkg::*;

	logic valid_s1;
	call_req_t req_s1;
	logic rsp_valid_q;
	dec_rsp_t rsp_q;
	logic [CALL_W-1:0] cabin_q;
	logic [CALL_W-1:0] hall_q;
	logic dir_q;
	logic adv;
	logic [CALL_W-1:0] cabin_m;
	logic [CALL_W-1:0] hall_m;
	dec_t dec;

	// Handshake: stage 1 moves on when the response register is empty or being read
	assign adv = valid_s1 && (!rsp_valid_q || !dec_stall);
	assign call_stall = valid_s1 && !adv;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!call_stall) begin
			valid_s1 <= call_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (call_valid && !call_stall) begin
			req_s1 <= call_req;
		end
	end

	// Latch new calls into the stored masks
	assign cabin_m = (cabin_q | req_s1.new_cabin_calls) & ALL_MASK;
	assign hall_m = (hall_q | req_s1.new_hall_calls) & ALL_MASK;

	ecdd_decide u_decide (
		.motion(req_s1.motion),
		.floor(req_s1.floor),
		.cabin(cabin_m),
		.hall(hall_m),
		.heading(dir_q),
		.dec(dec)
	);

	// Call state, updated once per request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cabin_q <= NO_CALLS;
			hall_q <= NO_CALLS;
			dir_q <= DIR_DOWN;
		end else if (adv) begin
			cabin_q <= dec.cabin_next;
			hall_q <= dec.hall_next;
			dir_q <= dec.heading;
		end
	end

	// Response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (adv) begin
			rsp_valid_q <= 1'b1;
		end else if (!dec_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rsp_q.command <= dec.command;
			rsp_q.heading <= dec.heading;
			rsp_q.pending_cabin <= dec.cabin_next;
			rsp_q.pending_hall <= dec.hall_next;
		end
	end

	assign dec_valid = rsp_valid_q;
	assign dec_rsp = rsp_q;

	// Call state only moves when a request is decided
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(cabin_q) && $stable(hall_q) && $stable(dir_q))
		else $error("call state changed without a request");

	// An error decision keeps the direction flag
	a_err_keeps_dir: assert property (@(posedge clk) disable iff (!arst_n)
		adv && dec.command == CMD_ERR |=> dir_q == $past(dir_q))
		else $error("error decision changed direction flag");

	// Up implies heading up, down implies heading down
	a_up_heading: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_q.command == CMD_UP |-> rsp_q.heading == DIR_UP)
		else $error("up command with heading down");

	a_down_heading: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_q.command == CMD_DOWN |-> rsp_q.heading == DIR_DOWN)
		else $error("down command with heading up");

	// Reported masks match the stored state
	a_rsp_state: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> rsp_q.pending_cabin == cabin_q && rsp_q.pending_hall == hall_q)
		else $error("response masks differ from stored state");

endmodule
`default_nettype wire
